@@ hdl/six_channel_moving_average_assert.svh @@
// assertion macros shared by the moving average checker
`ifndef SIX_CHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define SIX_CHANNEL_MOVING_AVERAGE_ASSERT_SVH

// property checked on every rising clk edge, idle while arst_n is low
`define SMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// once cond holds, sig keeps its value in the next cycle
`define SMA_ASSERT_HOLD(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

@@ hdl/sma_pkg.sv @@
// types, sizes and divider constants of the six channel moving average
`timescale 1ns / 1ps

package sma_pkg;

	// window and channel counts
	localparam int WINDOW_LEN   = 100;
	localparam int NUM_CHANNELS = 6;
	localparam int MAX_CHANNELS = 6;

	// field and state widths
	localparam int SPEED_W = 16;
	localparam int SLOT_W  = $clog2(WINDOW_LEN);
	localparam int SUM_W   = SPEED_W + $clog2(WINDOW_LEN);

	// reciprocal divide by WINDOW_LEN, exact for every magnitude below 2**SUM_W
	localparam int ABS_W     = SUM_W;
	localparam int MUL_W     = ABS_W + 1;
	localparam int DIV_SHIFT = ABS_W + $clog2(WINDOW_LEN);
	localparam int PROD_W    = ABS_W + MUL_W;
	localparam int QMAG_W    = PROD_W - DIV_SHIFT;
	localparam logic [MUL_W-1:0] DIV_MULT =
		MUL_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	// item commands
	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef speed_t [NUM_CHANNELS-1:0] speed_vec_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef sum_t [NUM_CHANNELS-1:0]   sum_vec_t;
	typedef logic [SLOT_W-1:0]         slot_t;

	// window memory control
	typedef struct packed {
		logic  rd_en;
		logic  wr_en;
		slot_t rd_addr;
		slot_t wr_addr;
	} ram_ctl_t;

endpackage

@@ hdl/sma_window_ram.sv @@
// window memory: one row of all channel samples per slot
`timescale 1ns / 1ps

module sma_window_ram (
	input  logic              clk,
	input  sma_pkg::ram_ctl_t ctl,
	input  sma_pkg::speed_vec_t wr_data,
	output sma_pkg::speed_vec_t rd_data
);

	sma_pkg::speed_vec_t mem [sma_pkg::WINDOW_LEN];
	sma_pkg::speed_vec_t rd_data_q;

	// single write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/sma_sum_bank.sv @@
// running window sums, one per channel
`timescale 1ns / 1ps

module sma_sum_bank (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  logic                wrapped,
	input  sma_pkg::speed_vec_t new_val,
	input  sma_pkg::speed_vec_t old_val,
	output sma_pkg::sum_vec_t   sums
);

	sma_pkg::sum_vec_t   sums_q;
	sma_pkg::speed_vec_t old_eff;

	// slots not yet written since reset hold zero
	assign old_eff = wrapped ? old_val : '0;

	// add the new sample, drop the oldest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (upd) begin
			for (int c = 0; c < sma_pkg::NUM_CHANNELS; c++) begin
				sums_q[c] <= sums_q[c] + sma_pkg::SUM_W'(new_val[c])
					- sma_pkg::SUM_W'(old_eff[c]);
			end
		end
	end

	assign sums = sums_q;

endmodule

@@ hdl/sma_div.sv @@
// divide one window sum by the window length, truncating toward zero
`timescale 1ns / 1ps

module sma_div (
	input  logic            clk,
	input  logic            load,
	input  sma_pkg::sum_t   sum,
	output sma_pkg::speed_t quot
);

	logic [sma_pkg::ABS_W-1:0]  mag;
	logic [sma_pkg::PROD_W-1:0] prod_s2;
	logic                       neg_s2;
	logic [sma_pkg::QMAG_W-1:0] qmag;
	logic [sma_pkg::QMAG_W-1:0] qsigned;

	// magnitude of the sum
	assign mag = sum[sma_pkg::SUM_W-1] ? sma_pkg::ABS_W'(-sum) : sma_pkg::ABS_W'(sum);

	// reciprocal multiply, registered
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2 <= sma_pkg::PROD_W'(mag) * sma_pkg::PROD_W'(sma_pkg::DIV_MULT);
			neg_s2  <= sum[sma_pkg::SUM_W-1];
		end
	end

	// shift out the fraction and restore the sign
	assign qmag    = prod_s2[sma_pkg::PROD_W-1:sma_pkg::DIV_SHIFT];
	assign qsigned = neg_s2 ? -qmag : qmag;
	assign quot    = qsigned[sma_pkg::SPEED_W-1:0];

endmodule

@@ hdl/six_channel_moving_average.sv @@
// top level of the six channel boxcar moving average
//
//  channel  handshake                    payload
//  item     item_valid / item_ready      cmd, speed_0 .. speed_5
//  result   result_valid / result_ready  avg_0 .. avg_5
//
// one item is taken per cycle while item_ready is high; a push passes the input register and
// then updates the window memory and running sums, and a tick passes the input register,
// multiply register and result register before its result shows
// the window memory needs no clearing pass: a wrap flag marks slots unwritten since reset
// a stalled result blocks the item side only once ticks fill the input and multiply stages
`timescale 1ns / 1ps

module six_channel_moving_average (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  logic cmd,
	input  logic signed [15:0] speed_0,
	input  logic signed [15:0] speed_1,
	input  logic signed [15:0] speed_2,
	input  logic signed [15:0] speed_3,
	input  logic signed [15:0] speed_4,
	input  logic signed [15:0] speed_5,
	output logic result_valid,
	input  logic result_ready,
	output logic signed [15:0] avg_0,
	output logic signed [15:0] avg_1,
	output logic signed [15:0] avg_2,
	output logic signed [15:0] avg_3,
	output logic signed [15:0] avg_4,
	output logic signed [15:0] avg_5
);

	sma_pkg::speed_t     speed_all [sma_pkg::MAX_CHANNELS];
	sma_pkg::speed_t     avg_all   [sma_pkg::MAX_CHANNELS];
	sma_pkg::speed_vec_t speed_in;

	// pipeline state
	logic                valid_s1;
	logic                tick_s1;
	sma_pkg::speed_vec_t speed_s1;
	sma_pkg::slot_t      slot_s1;
	logic                wrapped_s1;
	logic                valid_s2;
	logic                out_valid_q;
	sma_pkg::speed_vec_t avg_q;
	sma_pkg::slot_t      slot_q;
	logic                wrapped_q;

	// handshake and stage moves
	logic                out_take;
	logic                s2_free;
	logic                s1_adv;
	logic                accept;
	logic                accept_push;
	logic                push_s1;
	logic                load_s2;

	sma_pkg::ram_ctl_t   ram_ctl;
	sma_pkg::speed_vec_t old_row;
	sma_pkg::sum_vec_t   sums;
	sma_pkg::speed_vec_t quot;

	// gather payload ports
	assign speed_all[0] = speed_0;
	assign speed_all[1] = speed_1;
	assign speed_all[2] = speed_2;
	assign speed_all[3] = speed_3;
	assign speed_all[4] = speed_4;
	assign speed_all[5] = speed_5;

	always_comb begin
		for (int c = 0; c < sma_pkg::NUM_CHANNELS; c++) begin
			speed_in[c] = speed_all[c];
		end
	end

	// stage flow control
	assign out_take    = !out_valid_q || result_ready;
	assign s2_free     = !valid_s2 || out_take;
	assign s1_adv      = !valid_s1 || !tick_s1 || s2_free;
	assign item_ready  = s1_adv;
	assign accept      = item_valid && s1_adv;
	assign accept_push = accept && (cmd == sma_pkg::CMD_PUSH);
	assign push_s1     = valid_s1 && !tick_s1;
	assign load_s2     = valid_s1 && tick_s1 && s2_free;

	// oldest slot pointer and wrap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (accept_push) begin
			if (slot_q == sma_pkg::SLOT_W'(sma_pkg::WINDOW_LEN - 1)) begin
				slot_q    <= '0;
				wrapped_q <= 1'b1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1    <= (cmd == sma_pkg::CMD_TICK);
			speed_s1   <= speed_in;
			slot_s1    <= slot_q;
			wrapped_s1 <= wrapped_q;
		end
	end

	// window memory: read the oldest row when a push is accepted, overwrite it in the next cycle
	assign ram_ctl.rd_en   = accept_push;
	assign ram_ctl.rd_addr = slot_q;
	assign ram_ctl.wr_en   = push_s1;
	assign ram_ctl.wr_addr = slot_s1;

	sma_window_ram u_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.wr_data (speed_s1),
		.rd_data (old_row)
	);

	sma_sum_bank u_sums (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (push_s1),
		.wrapped (wrapped_s1),
		.new_val (speed_s1),
		.old_val (old_row),
		.sums    (sums)
	);

	// one divider lane per channel
	for (genvar c = 0; c < sma_pkg::NUM_CHANNELS; c++) begin : g_div
		sma_div u_div (
			.clk  (clk),
			.load (load_s2),
			.sum  (sums[c]),
			.quot (quot[c])
		);
	end

	// multiply stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= load_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && valid_s2) begin
			avg_q <= quot;
		end
	end

	// spread results to ports, unused channels read zero
	for (genvar c = 0; c < sma_pkg::MAX_CHANNELS; c++) begin : g_out
		if (c < sma_pkg::NUM_CHANNELS) begin : g_used
			assign avg_all[c] = avg_q[c];
		end else begin : g_unused
			assign avg_all[c] = '0;
		end
	end

	assign result_valid = out_valid_q;
	assign avg_0 = avg_all[0];
	assign avg_1 = avg_all[1];
	assign avg_2 = avg_all[2];
	assign avg_3 = avg_all[3];
	assign avg_4 = avg_all[4];
	assign avg_5 = avg_all[5];

endmodule

@@ hdl/sma_check.sv @@
// port level checker for the moving average, bound to the top level
`timescale 1ns / 1ps
`include "six_channel_moving_average_assert.svh"

module sma_check (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic cmd,
	input logic signed [15:0] speed_0,
	input logic signed [15:0] speed_1,
	input logic signed [15:0] speed_2,
	input logic signed [15:0] speed_3,
	input logic signed [15:0] speed_4,
	input logic signed [15:0] speed_5,
	input logic result_valid,
	input logic result_ready,
	input logic signed [15:0] avg_0,
	input logic signed [15:0] avg_1,
	input logic signed [15:0] avg_2,
	input logic signed [15:0] avg_3,
	input logic signed [15:0] avg_4,
	input logic signed [15:0] avg_5
);

	logic in_idle;
	logic [95:0] avg_all;
	logic [111:0] item_all;

	// no transaction on the item side while results drain freely
	assign in_idle  = !(item_valid && item_ready) && result_ready;
	assign avg_all  = {avg_5, avg_4, avg_3, avg_2, avg_1, avg_0};
	assign item_all = {speed_5, speed_4, speed_3, speed_2, speed_1, speed_0, 15'd0, cmd};

	// an empty or draining result register never blocks the item side
	`SMA_ASSERT(a_ready_free, (!result_valid || result_ready) |-> item_ready, "item_ready low")

	// idle cycles with the output taken, enough to empty the input, multiply and result registers, leave no result behind
	`SMA_ASSERT(a_drain, in_idle ##1 in_idle ##1 in_idle |=> !result_valid, "result after drain")

	// a waiting result stays put
	`SMA_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid, "result_valid dropped")
	`SMA_ASSERT_HOLD(a_avg_hold, result_valid && !result_ready, avg_all, "result changed in stall")

	// a waiting item transaction keeps its payload
	`SMA_ASSERT_HOLD(a_item_hold, item_valid && !item_ready, item_all, "item changed in stall")

endmodule

bind six_channel_moving_average sma_check u_sma_check (.*);

@@ tb/tb.sv @@
// self-checking testbench for the six channel boxcar moving average
`timescale 1ns / 1ps

module tb;

	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 950;
	localparam int CALM_ITEMS    = 150;
	localparam int REPORT_LIMIT  = 10;

	// one speed or average per channel, channel 0 in the low bits
	typedef logic [sma_pkg::MAX_CHANNELS-1:0][15:0] joint_vec_t;

	// how the speeds of a run of samples are chosen
	typedef enum int {
		FILL_RANDOM,
		FILL_MAX,
		FILL_MIN,
		FILL_SMALL,
		FILL_EDGES
	} fill_mode_t;

	// boxcar predictor and queue of expected averages
	class avg_scoreboard;
		logic [15:0] window_hist [sma_pkg::WINDOW_LEN][sma_pkg::NUM_CHANNELS];
		int          run_sum [sma_pkg::NUM_CHANNELS];
		int          oldest;
		joint_vec_t  expected_avgs [$];
		int          errors;

		function new();
			foreach (window_hist[s, ch])
				window_hist[s][ch] = '0;
			foreach (run_sum[ch])
				run_sum[ch] = 0;
			oldest = 0;
			errors = 0;
		endfunction

		// update the window on a sample, queue the averages on a tick
		function void note_item(sma_pkg::cmd_t c, joint_vec_t sp);
			joint_vec_t avgs;
			int q;
			if (c == sma_pkg::CMD_PUSH) begin
				for (int ch = 0; ch < sma_pkg::NUM_CHANNELS; ch++) begin
					run_sum[ch] = run_sum[ch] + $signed(sp[ch])
						- $signed(window_hist[oldest][ch]);
					window_hist[oldest][ch] = sp[ch];
				end
				oldest = (oldest + 1 == sma_pkg::WINDOW_LEN) ? 0 : oldest + 1;
			end else begin
				for (int ch = 0; ch < sma_pkg::MAX_CHANNELS; ch++) begin
					// signed division truncates toward zero
					q = (ch < sma_pkg::NUM_CHANNELS) ? run_sum[ch] / sma_pkg::WINDOW_LEN : 0;
					avgs[ch] = q[15:0];
				end
				expected_avgs = {expected_avgs, avgs};
			end
		endfunction

		// compare one delivered transaction with the oldest expectation
		function void check_result(joint_vec_t got);
			joint_vec_t want;
			if (expected_avgs.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result transaction at %0t", $realtime);
				return;
			end
			want = expected_avgs.pop_front();
			for (int ch = 0; ch < sma_pkg::MAX_CHANNELS; ch++) begin
				if (got[ch] !== want[ch]) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("avg_%0d mismatch at %0t: expected %0d, got %0d",
							ch, $realtime, $signed(want[ch]), $signed(got[ch]));
				end
			end
		endfunction

		function int outstanding();
			return expected_avgs.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	sma_pkg::cmd_t cmd;
	logic signed [15:0] speed_0, speed_1, speed_2, speed_3, speed_4, speed_5;
	logic result_valid;
	logic result_ready;
	logic signed [15:0] avg_0, avg_1, avg_2, avg_3, avg_4, avg_5;

	avg_scoreboard sb;
	bit idling;
	int items_sent;
	int quiet_cycles;
	int stall_left;

	six_channel_moving_average dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.cmd          (cmd),
		.speed_0      (speed_0),
		.speed_1      (speed_1),
		.speed_2      (speed_2),
		.speed_3      (speed_3),
		.speed_4      (speed_4),
		.speed_5      (speed_5),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.avg_0        (avg_0),
		.avg_1        (avg_1),
		.avg_2        (avg_2),
		.avg_3        (avg_3),
		.avg_4        (avg_4),
		.avg_5        (avg_5)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// pack six speeds into one vector
	function automatic joint_vec_t joints(logic [15:0] a, logic [15:0] b, logic [15:0] c,
		logic [15:0] d, logic [15:0] e, logic [15:0] f);
		joint_vec_t v;
		v[0] = a; v[1] = b; v[2] = c; v[3] = d; v[4] = e; v[5] = f;
		return v;
	endfunction

	// speeds of one sample under the given fill mode
	function automatic joint_vec_t pick_speeds(fill_mode_t mode);
		joint_vec_t v;
		logic [15:0] edges [5];
		int r;
		edges = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
		for (int ch = 0; ch < sma_pkg::MAX_CHANNELS; ch++) begin
			case (mode)
				FILL_MAX:   v[ch] = 16'h7FFF;
				FILL_MIN:   v[ch] = 16'h8000;
				FILL_SMALL: begin
					r = $urandom_range(0, 400) - 200;
					v[ch] = r[15:0];
				end
				FILL_EDGES: v[ch] = edges[$urandom_range(0, 4)];
				default:    v[ch] = 16'($urandom_range(0, 65535));
			endcase
		end
		return v;
	endfunction

	// drive one item transaction, at times after a random gap while idling, and wait until it is taken
	task automatic send_item(sma_pkg::cmd_t c, joint_vec_t sp);
		if (idling && $urandom_range(0, 2) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		speed_0    <= sp[0];
		speed_1    <= sp[1];
		speed_2    <= sp[2];
		speed_3    <= sp[3];
		speed_4    <= sp[4];
		speed_5    <= sp[5];
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_item(c, sp);
		items_sent++;
	endtask

	// result side back-pressure in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (idling && stall_left == 0 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 13);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(joints(avg_0, avg_1, avg_2, avg_3, avg_4, avg_5));
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		fill_mode_t mode;
		int run_len;
		int stop_at;

		sb           = new();
		idling       = 1'b1;
		items_sent   = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		result_ready = 1'b0;
		cmd          = sma_pkg::CMD_PUSH;
		speed_0      = '0;
		speed_1      = '0;
		speed_2      = '0;
		speed_3      = '0;
		speed_4      = '0;
		speed_5      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick on the empty window, speed fields must be ignored
		send_item(sma_pkg::CMD_TICK,
			joints(16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 16'h0001, 16'h5555));
		// extremes plus a small negative sum that truncates toward zero
		send_item(sma_pkg::CMD_PUSH,
			joints(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'hFF39));
		send_item(sma_pkg::CMD_TICK,
			joints(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_item(sma_pkg::CMD_PUSH,
			joints(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
		send_item(sma_pkg::CMD_PUSH,
			joints(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		send_item(sma_pkg::CMD_TICK,
			joints(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_item(sma_pkg::CMD_PUSH,
			joints(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_item(sma_pkg::CMD_PUSH,
			joints(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_item(sma_pkg::CMD_TICK,
			joints(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_item(sma_pkg::CMD_PUSH,
			joints(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_item(sma_pkg::CMD_PUSH,
			joints(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
		send_item(sma_pkg::CMD_TICK,
			joints(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(sma_pkg::CMD_TICK,
			joints(16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0020));

		// random runs of samples with ticks mixed in, long runs hold about a window length of items
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			idling  = (stop_at - items_sent > CALM_ITEMS) && ($urandom_range(0, 4) != 0);
			mode    = fill_mode_t'($urandom_range(0, 4));
			run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 110)
				: $urandom_range(1, 30);
			for (int i = 0; i < run_len; i++) begin
				if ($urandom_range(0, 4) == 0)
					send_item(sma_pkg::CMD_TICK, pick_speeds(FILL_RANDOM));
				else
					send_item(sma_pkg::CMD_PUSH, pick_speeds(mode));
			end
			send_item(sma_pkg::CMD_TICK, pick_speeds(FILL_RANDOM));
		end

		// drain and let the pipeline settle
		idling = 1'b0;
		item_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
